// File: rtl/pjpt_pkg.sv
// Shared types and codes for the priority job pool table.
package pjpt_pkg;

  typedef enum logic [3:0] {
    CMD_PUSH     = 4'd0,
    CMD_SET_CUR  = 4'd1,
    CMD_PUT      = 4'd2,
    CMD_SELECT   = 4'd3,
    CMD_MARK     = 4'd4,
    CMD_DEL_CUR  = 4'd5,
    CMD_DEL_ALL  = 4'd6,
    CMD_READ_CUR = 4'd7,
    CMD_READ_RES = 4'd8
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_FOUND  = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_FULL       = 3'd3,
    ST_NO_CURRENT = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    PROG_WAITING  = 2'd0,
    PROG_IN_USE   = 2'd1,
    PROG_COMPUTED = 2'd2
  } prog_e;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_SCAN = 2'd1,
    FSM_DONE = 2'd2,
    FSM_OUT  = 2'd3
  } fsm_e;

endpackage

// File: rtl/pjpt_cell.sv
// One table slot: holds an entry and compares it against the token passing by.
module pjpt_cell #(
  parameter int unsigned HW = 32,
  parameter int unsigned IW = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // token from the left neighbor
  input  logic          tk_vld_i,
  input  logic          tk_hit_i,     // best found so far
  input  logic [IW-1:0] tk_idx_i,
  input  logic [7:0]    tk_prio_i,
  input  logic [31:0]   tk_age_i,
  input  logic          tk_free_i,    // free slot seen
  input  logic [IW-1:0] tk_fidx_i,
  input  logic          tk_any_i,     // any used seen
  output logic          tk_vld_o,
  output logic          tk_hit_o,
  output logic [IW-1:0] tk_idx_o,
  output logic [7:0]    tk_prio_o,
  output logic [31:0]   tk_age_o,
  output logic          tk_free_o,
  output logic [IW-1:0] tk_fidx_o,
  output logic          tk_any_o,
  // command context, stable during a scan
  input  logic [IW-1:0] my_idx_i,
  input  logic          mode_sel_i,   // 1 select by priority, 0 match id
  input  logic [31:0]   key_id_i,
  input  logic [31:0]   stamp_i,
  // writes
  input  logic          clr_all_i,
  input  logic          free_i,
  input  logic          push_i,
  input  logic          upd_i,
  input  logic [1:0]    upd_prog_i,
  input  logic [HW-1:0] upd_oh_i,
  input  logic [31:0]   w_id_i,
  input  logic [7:0]    w_prio_i,
  input  logic [HW-1:0] w_ih_i,
  // entry view
  output logic          used_o,
  output logic [31:0]   id_o,
  output logic [7:0]    prio_o,
  output logic [1:0]    prog_o,
  output logic [HW-1:0] ih_o,
  output logic [HW-1:0] oh_o
);
  logic used_q;
  logic [31:0] id_q, stamp_q;
  logic [7:0] prio_q;
  logic [1:0] prog_q;
  logic [HW-1:0] ih_q, oh_q;
  logic [31:0] age;
  logic cand, better;

  assign age = stamp_i - stamp_q;
  always_comb begin
    if (mode_sel_i) begin
      cand = used_q && (prog_q == pjpt_pkg::PROG_WAITING);
      better = !tk_hit_i || (prio_q > tk_prio_i) ||
               ((prio_q == tk_prio_i) && (age > tk_age_i));
    end else begin
      cand = used_q && (id_q == key_id_i);
      better = !tk_hit_i || (age > tk_age_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tk_vld_o <= 1'b0;
      tk_hit_o <= 1'b0;
      tk_free_o <= 1'b0;
      tk_any_o <= 1'b0;
    end else begin
      tk_vld_o <= tk_vld_i;
      tk_hit_o <= tk_hit_i || cand;
      tk_free_o <= tk_free_i || !used_q;
      tk_any_o <= tk_any_i || used_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tk_idx_o <= (cand && better) ? my_idx_i : tk_idx_i;
    tk_prio_o <= (cand && better) ? prio_q : tk_prio_i;
    tk_age_o <= (cand && better) ? age : tk_age_i;
    tk_fidx_o <= (!tk_free_i && !used_q) ? my_idx_i : tk_fidx_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else if (clr_all_i || free_i) begin
      used_q <= 1'b0;
    end else if (push_i) begin
      used_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      id_q <= w_id_i;
      prio_q <= w_prio_i;
      prog_q <= pjpt_pkg::PROG_WAITING;
      ih_q <= w_ih_i;
      oh_q <= '0;
      stamp_q <= stamp_i;
    end else if (upd_i) begin
      prog_q <= upd_prog_i;
      oh_q <= upd_oh_i;
    end
  end

  assign used_o = used_q;
  assign id_o = id_q;
  assign prio_o = prio_q;
  assign prog_o = prog_q;
  assign ih_o = ih_q;
  assign oh_o = oh_q;
endmodule

// File: rtl/priority_job_pool_table_top.sv
// Top level of the priority job pool table: command port, cell chain, sequencer.
// After acceptance the command fields are registered and the search token enters
// the chain, walking the POOL_DEPTH slot cells one cell per cycle (lowest free
// slot, id match with oldest stamp, or best waiting priority); then the DONE state
// applies the write and the OUT state registers the result. One command is in
// flight at a time; the next is taken once the result register has been emptied.
module priority_job_pool_table_top #(
  parameter int unsigned POOL_DEPTH = 16,
  parameter int unsigned HANDLE_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // command[3:0], case_id[35:4], prio_level[43:36], in_handle[75:44],
  // out_handle[107:76], zero[111:108]
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0], found[3], result_id[35:4], result_prio[43:36],
  // result_in_handle[75:44], result_out_handle[107:76], result_state[109:108],
  // zero[111:110]
  output logic [111:0] m_axis_tdata
);
  localparam int unsigned IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned HW = HANDLE_WIDTH;
  localparam int unsigned CW = $clog2(POOL_DEPTH + 1);

  pjpt_pkg::fsm_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [3:0] cmd_q;
  logic [31:0] id_q;
  logic [7:0] prio_q;
  logic [HW-1:0] ih_q, oh_q;
  logic [31:0] stamp_q;
  logic [IW-1:0] cur_q;
  logic cur_vld_q;
  logic [111:0] out_q;
  logic out_vld_q;

  logic [HW-1:0] ih_in, oh_in;
  assign ih_in = HW >= 32 ? HW'(s_axis_tdata[75:44])
                          : HW'(s_axis_tdata[75:44] & 32'((64'd1 << HW) - 1));
  assign oh_in = HW >= 32 ? HW'(s_axis_tdata[107:76])
                          : HW'(s_axis_tdata[107:76] & 32'((64'd1 << HW) - 1));

  // chain wires
  logic          c_vld [POOL_DEPTH+1];
  logic          c_hit [POOL_DEPTH+1];
  logic [IW-1:0] c_idx [POOL_DEPTH+1];
  logic [7:0]    c_pr  [POOL_DEPTH+1];
  logic [31:0]   c_age [POOL_DEPTH+1];
  logic          c_fr  [POOL_DEPTH+1];
  logic [IW-1:0] c_fidx[POOL_DEPTH+1];
  logic          c_any [POOL_DEPTH+1];

  logic          e_used[POOL_DEPTH];
  logic [31:0]   e_id  [POOL_DEPTH];
  logic [7:0]    e_pr  [POOL_DEPTH];
  logic [1:0]    e_prog[POOL_DEPTH];
  logic [HW-1:0] e_ih  [POOL_DEPTH];
  logic [HW-1:0] e_oh  [POOL_DEPTH];

  logic start, apply;
  logic [IW-1:0] res_idx_q, fidx_q;
  logic hit_q, free_q, any_q, del_q;

  assign s_axis_tready = (state_q == pjpt_pkg::FSM_IDLE) && !out_vld_q;
  assign start = s_axis_tvalid && s_axis_tready;
  assign apply = (state_q == pjpt_pkg::FSM_DONE);

  // launch the token once the command fields are registered
  assign c_vld[0] = (state_q == pjpt_pkg::FSM_SCAN) && (cnt_q == '0);
  assign c_hit[0] = 1'b0;
  assign c_idx[0] = '0;
  assign c_pr[0] = '0;
  assign c_age[0] = '0;
  assign c_fr[0] = 1'b0;
  assign c_fidx[0] = '0;
  assign c_any[0] = 1'b0;

  logic is_push, is_put, is_mark, is_del;
  assign is_push = apply && (cmd_q == pjpt_pkg::CMD_PUSH) && free_q;
  assign is_put  = apply && (cmd_q == pjpt_pkg::CMD_PUT) && hit_q;
  assign is_mark = apply && (cmd_q == pjpt_pkg::CMD_MARK) && hit_q;
  assign is_del  = apply && (cmd_q == pjpt_pkg::CMD_DEL_CUR) && any_q && cur_vld_q &&
                   e_used[cur_q];

  for (genvar g = 0; g < POOL_DEPTH; g++) begin : g_cell
    pjpt_cell #(.HW(HW), .IW(IW)) u_cell (
      .clk_i, .rst_ni,
      .tk_vld_i(c_vld[g]), .tk_hit_i(c_hit[g]), .tk_idx_i(c_idx[g]),
      .tk_prio_i(c_pr[g]), .tk_age_i(c_age[g]), .tk_free_i(c_fr[g]),
      .tk_fidx_i(c_fidx[g]), .tk_any_i(c_any[g]),
      .tk_vld_o(c_vld[g+1]), .tk_hit_o(c_hit[g+1]), .tk_idx_o(c_idx[g+1]),
      .tk_prio_o(c_pr[g+1]), .tk_age_o(c_age[g+1]), .tk_free_o(c_fr[g+1]),
      .tk_fidx_o(c_fidx[g+1]), .tk_any_o(c_any[g+1]),
      .my_idx_i(IW'(g)),
      .mode_sel_i(cmd_q == pjpt_pkg::CMD_SELECT),
      .key_id_i(id_q), .stamp_i(stamp_q),
      .clr_all_i(apply && (cmd_q == pjpt_pkg::CMD_DEL_ALL)),
      .free_i(is_del && (cur_q == IW'(g))),
      .push_i(is_push && (fidx_q == IW'(g))),
      .upd_i((is_put || is_mark) && (res_idx_q == IW'(g))),
      .upd_prog_i(is_put ? pjpt_pkg::PROG_COMPUTED : pjpt_pkg::PROG_IN_USE),
      .upd_oh_i(is_put ? oh_q : '0),
      .w_id_i(id_q), .w_prio_i(prio_q), .w_ih_i(ih_q),
      .used_o(e_used[g]), .id_o(e_id[g]), .prio_o(e_pr[g]), .prog_o(e_prog[g]),
      .ih_o(e_ih[g]), .oh_o(e_oh[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pjpt_pkg::FSM_IDLE;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    case (state_q)
      pjpt_pkg::FSM_IDLE: begin
        if (start) begin
          state_d = pjpt_pkg::FSM_SCAN;
          cnt_d = '0;
        end
      end
      pjpt_pkg::FSM_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (c_vld[POOL_DEPTH]) state_d = pjpt_pkg::FSM_DONE;
      end
      pjpt_pkg::FSM_DONE: state_d = pjpt_pkg::FSM_OUT;
      pjpt_pkg::FSM_OUT: state_d = pjpt_pkg::FSM_IDLE;
      default: state_d = pjpt_pkg::FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      cmd_q <= s_axis_tdata[3:0];
      id_q <= s_axis_tdata[35:4];
      prio_q <= s_axis_tdata[43:36];
      ih_q <= ih_in;
      oh_q <= oh_in;
    end
    if (c_vld[POOL_DEPTH]) begin
      res_idx_q <= c_idx[POOL_DEPTH];
      fidx_q <= c_fidx[POOL_DEPTH];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
      free_q <= 1'b0;
      any_q <= 1'b0;
      del_q <= 1'b0;
      stamp_q <= '0;
      cur_q <= '0;
      cur_vld_q <= 1'b0;
    end else begin
      if (c_vld[POOL_DEPTH]) begin
        hit_q <= c_hit[POOL_DEPTH];
        free_q <= c_fr[POOL_DEPTH];
        any_q <= c_any[POOL_DEPTH];
      end
      // remember whether destroy current freed an entry
      if (apply) del_q <= is_del;
      if (is_push) stamp_q <= stamp_q + 32'd1;
      if (apply && hit_q && (cmd_q == pjpt_pkg::CMD_SET_CUR ||
                             cmd_q == pjpt_pkg::CMD_PUT)) begin
        cur_q <= res_idx_q;
        cur_vld_q <= 1'b1;
      end else if (is_del || (apply && cmd_q == pjpt_pkg::CMD_DEL_ALL)) begin
        cur_vld_q <= 1'b0;
      end
    end
  end

  // build the result from post-write entry contents
  logic [IW-1:0] rep_idx;
  logic rep;
  logic [2:0] st;
  logic fnd;
  logic cur_ok;
  logic [31:0] oh32, ih32;
  assign cur_ok = cur_vld_q && e_used[cur_q];
  always_comb begin
    rep = 1'b0;
    rep_idx = res_idx_q;
    st = pjpt_pkg::ST_OK;
    fnd = 1'b0;
    case (cmd_q)
      pjpt_pkg::CMD_PUSH: if (!free_q) st = pjpt_pkg::ST_FULL;
      pjpt_pkg::CMD_SET_CUR, pjpt_pkg::CMD_PUT, pjpt_pkg::CMD_MARK: begin
        if (hit_q) rep = 1'b1;
        else st = pjpt_pkg::ST_NOT_FOUND;
      end
      pjpt_pkg::CMD_SELECT: begin
        if (!any_q) st = pjpt_pkg::ST_EMPTY;
        else if (hit_q) begin
          rep = 1'b1;
          fnd = 1'b1;
        end
      end
      pjpt_pkg::CMD_DEL_CUR: begin
        if (!any_q) st = pjpt_pkg::ST_EMPTY;
        else if (!del_q) st = pjpt_pkg::ST_NO_CURRENT;
      end
      pjpt_pkg::CMD_READ_CUR: begin
        rep_idx = cur_q;
        if (!any_q) st = pjpt_pkg::ST_EMPTY;
        else if (!cur_ok) st = pjpt_pkg::ST_NO_CURRENT;
        else rep = 1'b1;
      end
      pjpt_pkg::CMD_READ_RES: begin
        if (!any_q) st = pjpt_pkg::ST_EMPTY;
        else if (!hit_q) st = pjpt_pkg::ST_NOT_FOUND;
        else rep = 1'b1;
      end
      default: ;
    endcase
  end
  assign ih32 = 32'(e_ih[rep_idx]);
  assign oh32 = (e_prog[rep_idx] == pjpt_pkg::PROG_COMPUTED) ? 32'(e_oh[rep_idx]) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (state_q == pjpt_pkg::FSM_OUT) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == pjpt_pkg::FSM_OUT) begin
      out_q <= rep ? {2'b00, e_prog[rep_idx], oh32, ih32, e_pr[rep_idx], e_id[rep_idx],
                      fnd, st}
                   : {108'd0, fnd, st};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata = out_q;

  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> state_q == pjpt_pkg::FSM_IDLE)
    else $error("result pending while busy");
  a_token_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_vld[POOL_DEPTH] |-> state_q == pjpt_pkg::FSM_SCAN)
    else $error("token left chain outside scan");
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pjpt_pkg::FSM_OUT |=> out_vld_q)
    else $error("result not raised");
  a_stamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !is_push |=> $stable(stamp_q))
    else $error("stamp moved without push");
endmodule

// File: tb/sv/tb_top.sv
// Testbench for the priority job pool table: command streams checked against a built-in predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  state;
    logic [31:0] out_handle;
    logic [31:0] in_handle;
    logic [7:0]  prio;
    logic [31:0] id;
    logic        found;
    logic [2:0]  status;
  } reply_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;

  priority_job_pool_table_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the job table
  logic            slot_used [DEPTH];
  logic [31:0]     slot_id   [DEPTH];
  logic [7:0]      slot_prio [DEPTH];
  pjpt_pkg::prog_e slot_prog [DEPTH];
  logic [31:0]     slot_ih   [DEPTH];
  logic [31:0]     slot_oh   [DEPTH];
  logic [31:0]     slot_stamp[DEPTH];
  logic [31:0]     stamp_ctr = '0;
  int              cur_slot = 0;
  logic            cur_valid = 1'b0;

  reply_t      expected_replies[$];
  int          fail_count = 0;
  int          idle_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_off = 1'b0;
  logic [31:0] known_ids[$];

  initial for (int k = 0; k < DEPTH; k++) slot_used[k] = 1'b0;

  function automatic bit table_is_empty();
    foreach (slot_used[k]) if (slot_used[k]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int oldest_with_id(logic [31:0] id);
    int best;
    logic [31:0] best_age, age;
    best = -1;
    best_age = '0;
    for (int k = 0; k < DEPTH; k++) begin
      if (!slot_used[k] || slot_id[k] != id) continue;
      age = stamp_ctr - slot_stamp[k];
      if (best < 0 || age > best_age) begin
        best = k;
        best_age = age;
      end
    end
    return best;
  endfunction

  function automatic void fill_case(ref reply_t r, input int k);
    r.id = slot_id[k];
    r.prio = slot_prio[k];
    r.in_handle = slot_ih[k];
    r.out_handle = (slot_prog[k] == pjpt_pkg::PROG_COMPUTED) ? slot_oh[k] : '0;
    r.state = slot_prog[k];
  endfunction

  // Apply one command to the shadow table and return the reply it yields.
  function automatic reply_t apply_command(logic [3:0] cmd, logic [31:0] id, logic [7:0] prio,
                                           logic [31:0] ih, logic [31:0] oh);
    reply_t r;
    int k, best;
    logic [31:0] age, best_age;
    r = '0;
    case (cmd)
      pjpt_pkg::CMD_PUSH: begin
        k = -1;
        for (int j = DEPTH - 1; j >= 0; j--) if (!slot_used[j]) k = j;
        if (k < 0) r.status = pjpt_pkg::ST_FULL;
        else begin
          slot_used[k] = 1'b1;
          slot_id[k] = id;
          slot_prio[k] = prio;
          slot_prog[k] = pjpt_pkg::PROG_WAITING;
          slot_ih[k] = ih;
          slot_oh[k] = '0;
          slot_stamp[k] = stamp_ctr;
          stamp_ctr++;
        end
      end
      pjpt_pkg::CMD_SET_CUR, pjpt_pkg::CMD_PUT, pjpt_pkg::CMD_MARK: begin
        k = oldest_with_id(id);
        if (k < 0) r.status = pjpt_pkg::ST_NOT_FOUND;
        else begin
          if (cmd == pjpt_pkg::CMD_PUT) begin
            slot_oh[k] = oh;
            slot_prog[k] = pjpt_pkg::PROG_COMPUTED;
          end
          if (cmd == pjpt_pkg::CMD_MARK) begin
            slot_oh[k] = '0;
            slot_prog[k] = pjpt_pkg::PROG_IN_USE;
          end else begin
            cur_slot = k;
            cur_valid = 1'b1;
          end
          fill_case(r, k);
        end
      end
      pjpt_pkg::CMD_SELECT: begin
        if (table_is_empty()) r.status = pjpt_pkg::ST_EMPTY;
        else begin
          best = -1;
          best_age = '0;
          for (int j = 0; j < DEPTH; j++) begin
            if (!slot_used[j] || slot_prog[j] != pjpt_pkg::PROG_WAITING) continue;
            age = stamp_ctr - slot_stamp[j];
            if (best < 0 || slot_prio[j] > slot_prio[best] ||
                (slot_prio[j] == slot_prio[best] && age > best_age)) begin
              best = j;
              best_age = age;
            end
          end
          if (best >= 0) begin
            r.found = 1'b1;
            fill_case(r, best);
          end
        end
      end
      pjpt_pkg::CMD_DEL_CUR: begin
        if (table_is_empty()) r.status = pjpt_pkg::ST_EMPTY;
        else if (!cur_valid || !slot_used[cur_slot]) r.status = pjpt_pkg::ST_NO_CURRENT;
        else begin
          slot_used[cur_slot] = 1'b0;
          cur_valid = 1'b0;
        end
      end
      pjpt_pkg::CMD_DEL_ALL: begin
        foreach (slot_used[j]) slot_used[j] = 1'b0;
        cur_valid = 1'b0;
      end
      pjpt_pkg::CMD_READ_CUR: begin
        if (table_is_empty()) r.status = pjpt_pkg::ST_EMPTY;
        else if (!cur_valid || !slot_used[cur_slot]) r.status = pjpt_pkg::ST_NO_CURRENT;
        else fill_case(r, cur_slot);
      end
      pjpt_pkg::CMD_READ_RES: begin
        if (table_is_empty()) r.status = pjpt_pkg::ST_EMPTY;
        else begin
          k = oldest_with_id(id);
          if (k < 0) r.status = pjpt_pkg::ST_NOT_FOUND;
          else fill_case(r, k);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Valid stays high after acceptance until the next item or idle_bus replaces it.
  task automatic send_command(logic [3:0] cmd, logic [31:0] id, logic [7:0] prio,
                              logic [31:0] ih, logic [31:0] oh);
    reply_t r;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, oh, ih, prio, id, cmd};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = apply_command(cmd, id, prio, ih, oh);
    expected_replies.insert(expected_replies.size(), r);
    if (cmd == pjpt_pkg::CMD_PUSH) known_ids.insert(known_ids.size(), id);
  endtask

  // Drop valid and wait for a clock edge.
  task automatic idle_bus();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Pick an id that usually hits a pushed case.
  function automatic logic [31:0] pick_id();
    if (known_ids.size() > 0 && $urandom_range(9) < 8)
      return known_ids[$urandom_range(known_ids.size() - 1)];
    return $urandom_range(7);
  endfunction

  task automatic send_random(int count);
    logic [3:0] cmd;
    int roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 30) cmd = pjpt_pkg::CMD_PUSH;
      else if (roll < 96)
        cmd = 4'($urandom_range(pjpt_pkg::CMD_READ_RES, pjpt_pkg::CMD_SET_CUR));
      else if (roll < 98) cmd = pjpt_pkg::CMD_DEL_ALL;
      else cmd = 4'($urandom_range(15, 9));
      if (cmd == pjpt_pkg::CMD_DEL_ALL) known_ids.delete();
      send_command(cmd, ($urandom_range(3) == 0) ? $urandom : pick_id(),
                   ($urandom_range(1) == 0) ? 8'($urandom_range(3)) : 8'($urandom),
                   $urandom, $urandom);
    end
  endtask

  task automatic wait_drained();
    idle_bus();
    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 10) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_command(pjpt_pkg::CMD_SELECT, 0, 0, 0, 0);
    send_command(pjpt_pkg::CMD_DEL_CUR, 0, 0, 0, 0);
    send_command(pjpt_pkg::CMD_READ_CUR, 0, 0, 0, 0);
    send_command(pjpt_pkg::CMD_READ_RES, 5, 0, 0, 0);
    send_command(pjpt_pkg::CMD_SET_CUR, 5, 0, 0, 0);
    send_command(pjpt_pkg::CMD_PUSH, 32'h8000_0000, 8'hff, 32'hffff_ffff, 0);
    send_command(pjpt_pkg::CMD_PUSH, 32'h7fff_ffff, 8'h00, 32'h0, 0);
    send_command(pjpt_pkg::CMD_PUSH, 32'h8000_0000, 8'hff, 32'h1234_5678, 0);
    send_command(pjpt_pkg::CMD_READ_CUR, 0, 0, 0, 0);
    send_command(pjpt_pkg::CMD_SELECT, 0, 0, 0, 0);
    send_command(pjpt_pkg::CMD_PUT, 32'h8000_0000, 0, 0, 32'hffff_ffff);
    send_command(pjpt_pkg::CMD_READ_RES, 32'h8000_0000, 0, 0, 0);
    send_command(pjpt_pkg::CMD_SELECT, 0, 0, 0, 0);
    send_command(pjpt_pkg::CMD_MARK, 32'h8000_0000, 0, 0, 0);
    send_command(pjpt_pkg::CMD_MARK, 32'h7fff_ffff, 0, 0, 0);
    send_command(pjpt_pkg::CMD_SELECT, 0, 0, 0, 0);
    send_command(pjpt_pkg::CMD_READ_CUR, 0, 0, 0, 0);
    send_command(pjpt_pkg::CMD_DEL_CUR, 0, 0, 0, 0);
    send_command(pjpt_pkg::CMD_DEL_CUR, 0, 0, 0, 0);
    send_command(pjpt_pkg::CMD_READ_RES, 32'h8000_0000, 0, 0, 0);
    send_command(4'd9, 1, 1, 1, 1);
    send_command(4'd15, 32'hffff_ffff, 8'hff, 32'hffff_ffff, 32'hffff_ffff);
    send_command(pjpt_pkg::CMD_DEL_ALL, 0, 0, 0, 0);
    known_ids.delete();
  endtask

  // Fill the table past capacity so pushes report full.
  task automatic test_full_table();
    for (int n = 0; n < DEPTH + 2; n++)
      send_command(pjpt_pkg::CMD_PUSH, 32'(n % 5), 8'($urandom_range(2)), $urandom, 0);
    for (int n = 0; n < 6; n++) send_command(pjpt_pkg::CMD_SELECT, 0, 0, 0, 0);
    send_command(pjpt_pkg::CMD_DEL_ALL, 0, 0, 0, 0);
    known_ids.delete();
  endtask

  task automatic test_random_phases();
    int pct[4][2] = '{'{0, 0}, '{45, 0}, '{0, 45}, '{31, 31}};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = pct[p][0];
      recv_stall_pct = pct[p][1];
      send_random(150);
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // Hold the result side for a long stretch while commands keep coming.
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        send_random(60);
        idle_bus();
      end
    join
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= !hold_off && !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
  end

  // Compare each reply with the oldest expectation.
  always @(posedge clk_i) begin
    reply_t got, want;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[109:0];
        if (expected_replies.size() == 0) begin
          $display("%0t: unexpected reply %h", $time, got);
          fail_count++;
        end else begin
          want = expected_replies.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
            fail_count++;
          end
          if (got.found !== want.found) begin
            $display("%0t: found exp %0d got %0d", $time, want.found, got.found);
            fail_count++;
          end
          if (got.id !== want.id) begin
            $display("%0t: id exp %h got %h", $time, want.id, got.id);
            fail_count++;
          end
          if (got.prio !== want.prio) begin
            $display("%0t: prio exp %h got %h", $time, want.prio, got.prio);
            fail_count++;
          end
          if (got.in_handle !== want.in_handle) begin
            $display("%0t: in_handle exp %h got %h", $time, want.in_handle, got.in_handle);
            fail_count++;
          end
          if (got.out_handle !== want.out_handle) begin
            $display("%0t: out_handle exp %h got %h", $time, want.out_handle, got.out_handle);
            fail_count++;
          end
          if (got.state !== want.state) begin
            $display("%0t: state exp %0d got %0d", $time, want.state, got.state);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_table();
    test_random_phases();
    test_backpressure();
    send_random(40);
    wait_drained();
    if (fail_count == 0 && expected_replies.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/pjpt_pkg.sv
rtl/pjpt_cell.sv
rtl/priority_job_pool_table_top.sv
tb/sv/tb_top.sv
